FILE: rtl/assert_macros.svh
// assertion macros for the rtl top level, mac_rx_frame_filter
// clocked property checks with and without a reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define MRFF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define MRFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mrff_pkg.sv
// shared types and constants of the receive frame filter
// no dependencies
`timescale 1ns / 1ps

package mrff_pkg;

   localparam int unsigned MAX_PAYLOAD     = 115;
   localparam int unsigned HEADER_AND_TAIL = 12;

   localparam logic [7:0] LEN_MIN = 8'(HEADER_AND_TAIL);
   localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + HEADER_AND_TAIL);

   // byte positions counted from the length byte (position 0)
   localparam logic [7:0] POS_LENGTH  = 8'd0;
   localparam logic [7:0] POS_FC      = 8'd1;
   localparam logic [7:0] POS_DEST_HI = 8'd6;
   localparam logic [7:0] POS_DEST_LO = 8'd7;
   localparam logic [7:0] POS_SRC_HI  = 8'd8;
   localparam logic [7:0] POS_SRC_LO  = 8'd9;
   localparam logic [7:0] POS_USER    = 8'd10;

   localparam logic [2:0] FRAME_TYPE_ACK = 3'd2;

   localparam int unsigned RSP_TDATA_W = 32;

   typedef enum logic [2:0] {
      ST_OK   = 3'd0,
      ST_ACK  = 3'd1,
      ST_DEST = 3'd2,
      ST_SRC  = 3'd3,
      ST_LEN  = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_OWN_ADDRESS  = 1'b0,
      CSR_PEER_ADDRESS = 1'b1
   } csr_index_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      status_type status;
      logic [7:0] user_type;
      logic [6:0] payload_length;
      logic       last;
   } result_type;

endpackage

FILE: rtl/mac_rx_frame_filter.sv
// receive frame address filter, top level
// depends on mrff_pkg, mrff_parse and assert_macros.svh
`timescale 1ns / 1ps
// usage:
//   req_* carries receive fifo bytes, one byte per beat, starting on a length byte.
//   rsp_* carries results: payload bytes of accepted frames (tuser 0) and one
//   status beat per frame (tuser 1, tlast 1) on the frame's final byte.
//   csr_* writes own address (index 0) and peer address (index 1); always ready.
//   write the addresses only while no frame is in progress.
// a result appears on rsp in the cycle after the byte that causes it is accepted.
// throughput: one byte per cycle unless rsp stalls; the frame state update and the address
//   compares fit between the input port and the result register.
// stall: the result register holds while rsp_tready is low; req_tready drops
//   only when that register is full and not being drained.
// rejected frames are consumed to their full length and give only a status beat.
// reset: clears the parser to expect a length byte, empties the result
//   register and loads the default addresses 0x1234 and 0x5678.
`include "assert_macros.svh"

module mac_rx_frame_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [7:0] payload_byte, [10:8] frame_status,
                                   // [18:11] frame_user_type, [25:19] payload_length
   output logic        rsp_tuser,  // [0] item_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0]          own_address_ff, peer_address_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   mrff_pkg::result_type rsp_item_ff;
   logic                 step;
   logic                 res_valid;
   mrff_pkg::result_type res;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff  <= 16'h1234;
         peer_address_ff <= 16'h5678;
      end else if (csr_valid && csr_ready) begin
         unique case (mrff_pkg::csr_index_type'(csr_index))
            mrff_pkg::CSR_OWN_ADDRESS:  own_address_ff  <= csr_data;
            mrff_pkg::CSR_PEER_ADDRESS: peer_address_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mrff_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (req_tdata),
      .own_address  (own_address_ff),
      .peer_address (peer_address_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step)
         rsp_valid_in = res_valid;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step && res_valid)
         rsp_item_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tlast  = rsp_item_ff.last;
   assign rsp_tdata  = {6'd0, rsp_item_ff.payload_length, rsp_item_ff.user_type,
                        rsp_item_ff.status, rsp_item_ff.payload_byte};

   `MRFF_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_tvalid, "result beat after reset")
   `MRFF_ASSERT(a_payload_clean, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[25:8] == 18'd0 && !rsp_tlast, "payload beat carries status fields")
   `MRFF_ASSERT(a_reject_no_len, clock, reset, rsp_tvalid && rsp_tuser && rsp_tdata[10:8] != 3'd0 |-> rsp_tdata[25:19] == 7'd0, "rejected frame reports payload length")
   `MRFF_ASSERT(a_stall_only_full, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready, "input stalled without full result register")

endmodule

FILE: rtl/mrff_parse.sv
// per-frame parser state and the per-beat filter decision
// depends on mrff_pkg
`timescale 1ns / 1ps

module mrff_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [15:0]         own_address,
   input  logic [15:0]         peer_address,
   output logic                res_valid,
   output mrff_pkg::result_type res
);

   logic [7:0]           byte_position_ff, byte_position_in;
   logic [7:0]           frame_length_ff, frame_length_in;
   mrff_pkg::status_type reject_code_ff, reject_code_in;
   logic [7:0]           address_high_byte_ff, address_high_byte_in;
   logic [7:0]           held_user_type_ff, held_user_type_in;
   logic [6:0]           payload_count_ff, payload_count_in;

   logic                 length_ok;
   logic [15:0]          addr;
   logic                 in_payload;
   logic                 is_end;
   mrff_pkg::status_type final_status;

   assign length_ok = (frame_length_ff >= mrff_pkg::LEN_MIN) &&
                      (frame_length_ff <= mrff_pkg::LEN_MAX);
   assign addr = {address_high_byte_ff, rx_byte};
   assign in_payload = (byte_position_ff > mrff_pkg::POS_USER) &&
                       ({1'b0, byte_position_ff} + 9'd2 <= {1'b0, frame_length_ff}) &&
                       length_ok;
   assign is_end = (byte_position_ff >= frame_length_ff);

   always_comb begin
      byte_position_in     = byte_position_ff;
      frame_length_in      = frame_length_ff;
      reject_code_in       = reject_code_ff;
      address_high_byte_in = address_high_byte_ff;
      held_user_type_in    = held_user_type_ff;
      payload_count_in     = payload_count_ff;
      res_valid            = 1'b0;
      res                  = '0;
      final_status         = mrff_pkg::ST_OK;

      if (byte_position_ff == mrff_pkg::POS_LENGTH) begin
         frame_length_in      = rx_byte;
         reject_code_in       = mrff_pkg::ST_OK;
         address_high_byte_in = 8'd0;
         held_user_type_in    = 8'd0;
         payload_count_in     = 7'd0;
         if (rx_byte == 8'd0) begin
            // zero length frame ends on its length byte
            res_valid   = 1'b1;
            res.kind    = mrff_pkg::KIND_STATUS;
            res.status  = mrff_pkg::ST_LEN;
            res.last    = 1'b1;
         end else begin
            byte_position_in = 8'd1;
         end
      end else begin
         if (reject_code_ff == mrff_pkg::ST_OK) begin
            unique case (byte_position_ff)
               mrff_pkg::POS_FC: begin
                  if (rx_byte[2:0] == mrff_pkg::FRAME_TYPE_ACK)
                     reject_code_in = mrff_pkg::ST_ACK;
               end
               mrff_pkg::POS_DEST_HI, mrff_pkg::POS_SRC_HI: begin
                  address_high_byte_in = rx_byte;
               end
               mrff_pkg::POS_DEST_LO: begin
                  if (addr != own_address)
                     reject_code_in = mrff_pkg::ST_DEST;
               end
               mrff_pkg::POS_SRC_LO: begin
                  if (addr != peer_address)
                     reject_code_in = mrff_pkg::ST_SRC;
               end
               mrff_pkg::POS_USER: begin
                  held_user_type_in = rx_byte;
               end
               default: begin
                  if (in_payload) begin
                     res_valid        = 1'b1;
                     res.kind         = mrff_pkg::KIND_PAYLOAD;
                     res.payload_byte = rx_byte;
                     payload_count_in = payload_count_ff + 7'd1;
                  end
               end
            endcase
         end

         if (is_end) begin
            final_status = reject_code_in;
            if (final_status == mrff_pkg::ST_OK && !length_ok)
               final_status = mrff_pkg::ST_LEN;
            res_valid          = 1'b1;
            res                = '0;
            res.kind           = mrff_pkg::KIND_STATUS;
            res.status         = final_status;
            res.user_type      = held_user_type_in;
            res.payload_length = (final_status == mrff_pkg::ST_OK) ? payload_count_in : 7'd0;
            res.last           = 1'b1;
            byte_position_in   = mrff_pkg::POS_LENGTH;
         end else begin
            byte_position_in = byte_position_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff     <= '0;
         frame_length_ff      <= '0;
         reject_code_ff       <= mrff_pkg::ST_OK;
         address_high_byte_ff <= '0;
         held_user_type_ff    <= '0;
         payload_count_ff     <= '0;
      end else if (step) begin
         byte_position_ff     <= byte_position_in;
         frame_length_ff      <= frame_length_in;
         reject_code_ff       <= reject_code_in;
         address_high_byte_ff <= address_high_byte_in;
         held_user_type_ff    <= held_user_type_in;
         payload_count_ff     <= payload_count_in;
      end
   end

endmodule

FILE: test/tb.sv
// testbench for mac_rx_frame_filter: drives receive fifo bytes, predicts payload and
// status beats with a byte-level frame parser of its own and checks every result beat
// depends on mrff_pkg and mac_rx_frame_filter
`timescale 1ns / 1ps

module tb;
   import mrff_pkg::*;

   localparam int ITEMS_TOTAL    = 1950;
   localparam int PHASES         = 5;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AFTER     = 1000;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [7:0] data;
      bit         typed;
      result_type res;
   } stim_row;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = 8'h00;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_OWN_ADDRESS;
   logic [15:0]   csr_data = 16'h0000;

   // parser state and address copies of the predictor
   logic [7:0]  f_pos, f_len, f_addr_hi, f_user;
   status_type  f_reject;
   logic [6:0]  f_count;
   logic [15:0] own_addr, peer_addr;

   result_type  pending_results[$];
   result_type  want;
   int          errors = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          req_idle_pct = 30;

   always #10 clock = ~clock;

   mac_rx_frame_filter i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   function automatic bit length_fits();
      return f_len >= LEN_MIN && f_len <= LEN_MAX;
   endfunction

   function automatic result_type status_beat(status_type st, logic [7:0] user,
                                              logic [6:0] count);
      result_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      r.user_type = user;
      r.payload_length = count;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic result_type frame_end_beat();
      status_type st;
      st = f_reject;
      if (st == ST_OK && !length_fits())
         st = ST_LEN;
      return status_beat(st, f_user, (st == ST_OK) ? f_count : 7'd0);
   endfunction

   // one fifo byte through the parser; returns 1 when it causes a result beat
   function automatic bit filter_byte(input logic [7:0] b, output result_type res);
      logic [15:0] addr;
      bit          hit;
      hit = 1'b0;
      res = '0;
      if (f_pos == POS_LENGTH) begin
         f_len = b;
         f_reject = ST_OK;
         f_addr_hi = 8'h00;
         f_user = 8'h00;
         f_count = 7'd0;
         if (b == 8'h00) begin
            res = frame_end_beat();
            return 1'b1;
         end
         f_pos = POS_FC;
         return 1'b0;
      end
      if (f_reject == ST_OK) begin
         addr = {f_addr_hi, b};
         case (f_pos)
            POS_FC: if (b[2:0] == FRAME_TYPE_ACK) f_reject = ST_ACK;
            POS_DEST_HI, POS_SRC_HI: f_addr_hi = b;
            POS_DEST_LO: if (addr != own_addr) f_reject = ST_DEST;
            POS_SRC_LO: if (addr != peer_addr) f_reject = ST_SRC;
            POS_USER: f_user = b;
            default: begin
               if (f_pos > POS_USER && {1'b0, f_pos} + 9'd2 <= {1'b0, f_len}
                   && length_fits()) begin
                  res.kind = KIND_PAYLOAD;
                  res.payload_byte = b;
                  f_count = f_count + 7'd1;
                  hit = 1'b1;
               end
            end
         endcase
      end
      if (f_pos >= f_len) begin
         res = frame_end_beat();
         f_pos = POS_LENGTH;
         return 1'b1;
      end
      f_pos = f_pos + 8'd1;
      return hit;
   endfunction

   // mostly no gap, mostly short gaps, now and then a long one
   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct)
         return 0;
      if ($urandom_range(9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send_byte(input logic [7:0] b, output bit got, output result_type res);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      got = filter_byte(b, res);
   endtask

   task automatic send_random_frame();
      logic [7:0] frame[$];
      logic [7:0] b;
      int         len;
      int         r;
      bit         dest_ok, src_ok, got;
      result_type res;
      r = $urandom_range(99);
      if (r < 66)
         len = LEN_MIN + $urandom_range(16);
      else if (r < 76)
         len = LEN_MIN + $urandom_range(17, MAX_PAYLOAD);
      else if (r < 82)
         len = $urandom_range(1) ? LEN_MAX : LEN_MIN;
      else if (r < 96)
         len = $urandom_range(11);
      else
         len = $urandom_range(LEN_MAX + 1, 255);
      dest_ok = $urandom_range(99) < 85;
      src_ok = $urandom_range(99) < 85;
      case ($urandom_range(3))
         0, 1: req_idle_pct = 0;
         2: req_idle_pct = 15;
         default: req_idle_pct = 40;
      endcase
      frame.push_back(8'(len));
      for (int p = 1; p <= len; p++) begin
         b = 8'($urandom);
         case (8'(p))
            POS_FC: if ($urandom_range(99) < 12) b[2:0] = FRAME_TYPE_ACK;
            POS_DEST_HI: if (dest_ok) b = own_addr[15:8];
            POS_DEST_LO: if (dest_ok) b = own_addr[7:0];
            POS_SRC_HI: if (src_ok) b = peer_addr[15:8];
            POS_SRC_LO: if (src_ok) b = peer_addr[7:0];
            default: ;
         endcase
         frame.push_back(b);
      end
      foreach (frame[i]) begin
         send_byte(frame[i], got, res);
         if (got)
            pending_results.push_back(res);
      end
   endtask

   task automatic write_addresses(input logic [15:0] own, input logic [15:0] peer);
      csr_valid <= 1'b1;
      csr_index <= CSR_OWN_ADDRESS;
      csr_data <= own;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      own_addr = own;
      csr_index <= CSR_PEER_ADDRESS;
      csr_data <= peer;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      peer_addr = peer;
      csr_valid <= 1'b0;
   endtask

   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name,
                  exp_val, act_val);
         errors++;
      end
   endtask

   initial begin : stimulus
      stim_row    rows[$];
      bit         got;
      result_type res;
      f_pos = POS_LENGTH;
      f_len = 8'h00;
      f_reject = ST_OK;
      f_addr_hi = 8'h00;
      f_user = 8'h00;
      f_count = 7'd0;
      own_addr = 16'h1234;
      peer_addr = 16'h5678;
      rows = '{
         // zero length
         '{8'h00, 1'b1, status_beat(ST_LEN, 8'h00, 7'd0)},
         // one byte frame, too short
         '{8'h01, 1'b0, '0}, '{8'h80, 1'b1, status_beat(ST_LEN, 8'h00, 7'd0)},
         // ack frame type, short
         '{8'h02, 1'b0, '0}, '{8'hFA, 1'b0, '0},
         '{8'h00, 1'b1, status_beat(ST_ACK, 8'h00, 7'd0)},
         // wrong destination ends a short frame, ahead of the length check
         '{8'h07, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h5A, 1'b0, '0},
         '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
         '{8'h12, 1'b0, '0},
         '{8'h35, 1'b1, status_beat(ST_DEST, 8'h00, 7'd0)},
         // accepted frame with one payload byte
         '{8'h0D, 1'b0, '0}, '{8'h41, 1'b0, '0}, '{8'h88, 1'b0, '0},
         '{8'h7F, 1'b0, '0}, '{8'hCD, 1'b0, '0}, '{8'hAB, 1'b0, '0},
         '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h56, 1'b0, '0},
         '{8'h78, 1'b0, '0}, '{8'hA5, 1'b0, '0}, '{8'hFF, 1'b0, '0},
         '{8'h80, 1'b0, '0},
         '{8'h01, 1'b1, status_beat(ST_OK, 8'hA5, 7'd1)}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send_byte(rows[i].data, got, res);
         if (rows[i].typed)
            pending_results.push_back(rows[i].res);
         else if (got)
            pending_results.push_back(res);
      end
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            drain(4);
            case (ph)
               1: write_addresses(16'h0000, 16'hFFFF);
               2: write_addresses(16'hFFFF, 16'h0000);
               default: write_addresses(16'($urandom), 16'($urandom));
            endcase
         end
         while (items_sent < (ph + 1) * ITEMS_TOTAL / PHASES)
            send_random_frame();
      end
      drain(8);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // result side: stalls of random length, one long hold-off while the input keeps coming
   initial begin : rsp_side
      int  pct;
      int  gap;
      int  cycle_n;
      int  next_switch;
      bit  held;
      pct = 0;
      cycle_n = 0;
      next_switch = 0;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (cycle_n >= next_switch) begin
            case ($urandom_range(2))
               0: pct = 0;
               1: pct = 25;
               default: pct = 50;
            endcase
            next_switch = cycle_n + 64;
         end
         if (!held && items_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            cycle_n += LONG_HOLD;
         end else begin
            gap = pick_gap(pct);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
               cycle_n += gap;
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         cycle_n++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("item_kind", want.kind, rsp_tuser);
            check_field("payload_byte", want.payload_byte, rsp_tdata[7:0]);
            check_field("frame_status", want.status, rsp_tdata[10:8]);
            check_field("frame_user_type", want.user_type, rsp_tdata[18:11]);
            check_field("payload_length", want.payload_length, rsp_tdata[25:19]);
            check_field("tdata padding", 0, rsp_tdata[31:26]);
            check_field("frame_last", want.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mrff_pkg.sv
rtl/mrff_parse.sv
rtl/mac_rx_frame_filter.sv
test/tb.sv
